// ===== rtl/core/atc_pkg.sv =====
`timescale 1ns / 1ps

package atc_pkg;

   localparam int DATA_W            = 16;
   localparam int THRUST_W          = 17;
   localparam int LAG_W             = 4;
   localparam int GAIN_W            = 10;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;
   localparam int HISTORY_DEPTH_DEF = 16;

   // The divider retires one quotient bit per cycle over the sample width.
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_ALTITUDE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LAG_SELECT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_DIVISOR    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COARSE_BAND     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_THRUST      = 3'd5;

   localparam logic [DATA_W-1:0] TARGET_ALTITUDE_RST = 16'd0;
   localparam logic [DATA_W-1:0] TOLERANCE_RST       = 16'd20;
   localparam logic [LAG_W-1:0]  LAG_SELECT_RST      = 4'd1;
   localparam logic [GAIN_W-1:0] GAIN_DIVISOR_RST    = 10'd10;
   localparam logic [DATA_W-1:0] COARSE_BAND_RST     = 16'd800;
   localparam logic [DATA_W-1:0] MAX_THRUST_RST      = 16'd255;

   typedef enum logic [1:0] {
      CASE_BRAKE = 2'd0,
      CASE_HOLD  = 2'd1,
      CASE_PROP  = 2'd2,
      CASE_SAT   = 2'd3
   } ctrl_case_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic              negate;
      logic [DATA_W-1:0] dividend;
      logic [GAIN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                       done;
      logic signed [THRUST_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/atc_req_if.sv =====
`timescale 1ns / 1ps

interface atc_req_if;
   logic                      valid;
   logic                      ready;
   logic [atc_pkg::DATA_W-1:0] altitude_sample;

   modport source (output valid, output altitude_sample, input ready);
   modport sink   (input valid, input altitude_sample, output ready);
endinterface

// ===== rtl/core/atc_rsp_if.sv =====
`timescale 1ns / 1ps

interface atc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [atc_pkg::THRUST_W-1:0] vertical_thrust;
   logic [1:0]                          control_case;

   modport source (output valid, output vertical_thrust, output control_case, input ready);
   modport sink   (input valid, input vertical_thrust, input control_case, output ready);
endinterface

// ===== rtl/core/atc_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider: the dividend shifts out of the quotient register one bit
// per cycle while the quotient bits shift in behind it.
module atc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  atc_pkg::div_cmd_type cmd,
   output atc_pkg::div_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [atc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [atc_pkg::GAIN_W-1:0]     rem_ff, rem_in;
   logic [atc_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [atc_pkg::GAIN_W-1:0]     den_ff, den_in;
   logic                           neg_ff, neg_in;
   logic [atc_pkg::GAIN_W:0]       trial;
   logic [atc_pkg::GAIN_W:0]       diff;
   logic                           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[atc_pkg::DATA_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.dividend;
         den_in  = cmd.divisor;
         neg_in  = cmd.negate;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it never needs an extra bit.
         rem_in = fits ? diff[atc_pkg::GAIN_W-1:0] : trial[atc_pkg::GAIN_W-1:0];
         quo_in = {quo_ff[atc_pkg::DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == atc_pkg::DIV_CNT_W'(atc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      rsp.done     = done_ff;
      rsp.quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   end

endmodule

// ===== rtl/core/altitude_thrust_controller_core.sv =====
`timescale 1ns / 1ps

// An accepted word whose thrust needs a division (brake and proportional cases)
// passes through the evaluate, 16-step serial divide and done states; hold and
// saturated results skip the divide state. A new word is taken only when idle.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, active high) restores the register defaults and empties the
// history; entries not yet written read as zero through the fill count.
module altitude_thrust_controller_core #(
   parameter int HISTORY_DEPTH = atc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   atc_req_if.sink                            req_chan,
   atc_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [atc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [atc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int LW = (AW > atc_pkg::LAG_W) ? AW : atc_pkg::LAG_W;
   localparam int DW = atc_pkg::DATA_W;
   localparam int TW = atc_pkg::THRUST_W;

   atc_pkg::state_type state_ff, state_in;

   logic [DW-1:0]              target_ff;
   logic [DW-1:0]              tolerance_ff;
   logic [atc_pkg::LAG_W-1:0]  lag_select_ff;
   logic [atc_pkg::GAIN_W-1:0] gain_ff;
   logic [DW-1:0]              coarse_ff;
   logic [DW-1:0]              max_thrust_ff;

   logic [DW-1:0] hist_mem [HISTORY_DEPTH];
   logic [AW-1:0] wp_ff;
   logic [FW-1:0] fill_ff;

   logic          accept;
   logic [LW-1:0] lag_wide;
   logic [AW-1:0] lag_eff;
   logic [AW:0]   rd_sum;
   logic [AW-1:0] rd_addr;
   logic          lag_hit;

   logic [DW-1:0] sample_ff;
   logic [DW-1:0] rdata_ff;
   logic          lag_zero_ff;
   logic          lag_hit_ff;

   logic [DW-1:0]        lagged;
   logic signed [TW-1:0] err_now, err_lag, trend;
   logic [TW-1:0]        abs_now, abs_lag, abs_trend;
   logic                 toward;
   logic                 is_brake, is_hold, is_prop;
   atc_pkg::ctrl_case_type eval_case;
   logic signed [TW-1:0] sat_thrust;

   logic                   load_res, cap_div, load_out;
   logic                   div_start;
   logic signed [TW-1:0]   res_thrust_ff;
   atc_pkg::ctrl_case_type res_case_ff;

   atc_pkg::div_cmd_type div_cmd;
   atc_pkg::div_rsp_type div_rsp;

   logic                   out_valid_ff;
   logic signed [TW-1:0]   out_thrust_ff;
   atc_pkg::ctrl_case_type out_case_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= atc_pkg::TARGET_ALTITUDE_RST;
         tolerance_ff  <= atc_pkg::TOLERANCE_RST;
         lag_select_ff <= atc_pkg::LAG_SELECT_RST;
         gain_ff       <= atc_pkg::GAIN_DIVISOR_RST;
         coarse_ff     <= atc_pkg::COARSE_BAND_RST;
         max_thrust_ff <= atc_pkg::MAX_THRUST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            atc_pkg::REG_TARGET_ALTITUDE: target_ff     <= csr_wr_data[DW-1:0];
            atc_pkg::REG_TOLERANCE:       tolerance_ff  <= csr_wr_data[DW-1:0];
            atc_pkg::REG_LAG_SELECT:      lag_select_ff <= csr_wr_data[atc_pkg::LAG_W-1:0];
            atc_pkg::REG_GAIN_DIVISOR:    gain_ff       <= csr_wr_data[atc_pkg::GAIN_W-1:0];
            atc_pkg::REG_COARSE_BAND:     coarse_ff     <= csr_wr_data[DW-1:0];
            atc_pkg::REG_MAX_THRUST:      max_thrust_ff <= csr_wr_data[DW-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_chan.valid && req_chan.ready;

   // The history is a circular buffer; the lagged entry sits lag_eff slots
   // behind the slot that the new word is written to.
   always_comb begin
      lag_wide = LW'(lag_select_ff);
      lag_eff  = (lag_wide > LW'(HISTORY_DEPTH - 1)) ? AW'(HISTORY_DEPTH - 1)
                                                     : lag_wide[AW-1:0];
      rd_sum   = ({1'b0, wp_ff} >= {1'b0, lag_eff})
                 ? ({1'b0, wp_ff} - {1'b0, lag_eff})
                 : ({1'b0, wp_ff} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, lag_eff});
      rd_addr  = rd_sum[AW-1:0];
      lag_hit  = FW'(lag_eff) <= fill_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wp_ff] <= req_chan.altitude_sample;
         rdata_ff        <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         wp_ff <= (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != FW'(HISTORY_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff   <= req_chan.altitude_sample;
         lag_zero_ff <= lag_eff == '0;
         lag_hit_ff  <= lag_hit;
      end
   end

   // Decision logic, evaluated in the cycle after the word is taken.
   always_comb begin
      lagged  = lag_zero_ff ? sample_ff : (lag_hit_ff ? rdata_ff : '0);
      err_now = $signed({1'b0, target_ff}) - $signed({1'b0, sample_ff});
      err_lag = $signed({1'b0, target_ff}) - $signed({1'b0, lagged});
      trend   = $signed({1'b0, lagged}) - $signed({1'b0, sample_ff});

      abs_now   = err_now[TW-1] ? TW'(-err_now) : TW'(err_now);
      abs_lag   = err_lag[TW-1] ? TW'(-err_lag) : TW'(err_lag);
      abs_trend = trend[TW-1] ? TW'(-trend) : TW'(trend);

      // The craft closes on the target when the trend and the lagged error
      // have opposite signs and neither is zero.
      toward = (err_lag[TW-1] && !trend[TW-1] && (trend != '0)) ||
               (!err_lag[TW-1] && (err_lag != '0) && trend[TW-1]);

      is_brake = (abs_lag > {1'b0, tolerance_ff}) && toward;
      is_hold  = abs_now < {1'b0, tolerance_ff};
      is_prop  = abs_now < {1'b0, coarse_ff};

      if (is_brake) begin
         eval_case = atc_pkg::CASE_BRAKE;
      end else if (is_hold) begin
         eval_case = atc_pkg::CASE_HOLD;
      end else if (is_prop) begin
         eval_case = atc_pkg::CASE_PROP;
      end else begin
         eval_case = atc_pkg::CASE_SAT;
      end

      sat_thrust = err_now[TW-1] ? -$signed({1'b0, max_thrust_ff})
                                 : $signed({1'b0, max_thrust_ff});
   end

   // Control sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      load_res  = 1'b0;
      cap_div   = 1'b0;
      load_out  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         atc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = atc_pkg::ST_EVAL;
            end
         end
         atc_pkg::ST_EVAL: begin
            load_res = 1'b1;
            if (eval_case == atc_pkg::CASE_BRAKE || eval_case == atc_pkg::CASE_PROP) begin
               div_start = 1'b1;
               state_in  = atc_pkg::ST_DIV;
            end else begin
               state_in = atc_pkg::ST_DONE;
            end
         end
         atc_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               cap_div  = 1'b1;
               state_in = atc_pkg::ST_DONE;
            end
         end
         atc_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = atc_pkg::ST_IDLE;
            end
         end
         default: state_in = atc_pkg::ST_IDLE;
      endcase
   end

   assign req_chan.ready = state_ff == atc_pkg::ST_IDLE;

   always_comb begin
      div_cmd.start    = div_start;
      div_cmd.negate   = is_brake ? trend[TW-1] : err_now[TW-1];
      div_cmd.dividend = is_brake ? abs_trend[DW-1:0] : abs_now[DW-1:0];
      div_cmd.divisor  = (gain_ff == '0) ? atc_pkg::GAIN_W'(1) : gain_ff;
   end

   atc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (load_res) begin
         res_case_ff   <= eval_case;
         res_thrust_ff <= (eval_case == atc_pkg::CASE_SAT) ? sat_thrust : '0;
      end else if (cap_div) begin
         res_thrust_ff <= div_rsp.quotient;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_thrust_ff <= res_thrust_ff;
         out_case_ff   <= res_case_ff;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.vertical_thrust = out_thrust_ff;
   assign rsp_chan.control_case    = out_case_ff;

endmodule

// ===== rtl/core/atc_checker.sv =====
`timescale 1ns / 1ps

module atc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [atc_pkg::THRUST_W-1:0] rsp_vertical_thrust,
   input logic [1:0]                          rsp_control_case
);

   // A result word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // A stalled result word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_vertical_thrust) && $stable(rsp_control_case))
      else $error("stalled result word changed");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   // The hold case always commands zero thrust.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_control_case == atc_pkg::CASE_HOLD |-> rsp_vertical_thrust == '0)
      else $error("hold result with nonzero thrust");

endmodule

bind altitude_thrust_controller_core atc_checker u_atc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_vertical_thrust (rsp_chan.vertical_thrust),
   .rsp_control_case    (rsp_chan.control_case)
);
